>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the daily alarm scheduler.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/das_pkg.sv
// Package of the daily alarm scheduler: item types, register map and constants.
// Depends on nothing; used by every module of the block.
package das_pkg;

  localparam int SLOTS    = 6;
  localparam int IDX_W    = 3;
  localparam int EVENT_W  = 46;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 6;
  localparam int DIST_W   = 18;
  localparam int DAY_SECS = 86400;
  localparam int MIN_RECIP = 139811;
  localparam int MIN_SHIFT = 23;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_NEXT   = 2'd1;
  localparam logic [1:0] MODE_CHANGE = 2'd2;
  localparam logic [1:0] MODE_SHOW   = 2'd3;

  localparam logic [1:0] KIND_FIRE = 2'd0;
  localparam logic [1:0] KIND_NEXT = 2'd1;
  localparam logic [1:0] KIND_SHOW = 2'd2;

  localparam logic [2:0] REG_COUNT  = 3'd0;
  localparam logic [2:0] REG_EVENT0 = 3'd1;

  localparam logic [26:0] DAY_NONE   = '1;
  localparam logic [10:0] MINUTE_NONE = 11'h7FF;

  typedef struct packed {
    logic [31:0] duration;
    logic [1:0]  action;
    logic [10:0] minute;
    logic        enable;
  } event_t;

  typedef struct packed {
    logic [2:0]               count;
    event_t [SLOTS-1:0]       events;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [26:0] day_code;
    logic [16:0] sec_of_day;
    logic        clock_ok;
    logic [1:0]  current_app_mode;
    logic        cycle_on;
    logic [31:0] cycle_left_sec;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        found;
    logic [2:0]  slot_index;
    logic [10:0] event_minute;
    logic [1:0]  event_action;
    logic [31:0] event_duration;
    logic [31:0] wait_sec;
    logic        mode_differs;
    logic        last;
  } out_item_t;

endpackage

>>> hw/rtl/das_regs.sv
// Configuration registers of the daily alarm scheduler behind an APB-style port.
// Depends on das_pkg.
module das_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [das_pkg::ADDR_W-1:0]  paddr,
  input  logic [das_pkg::DATA_W-1:0]  pwdata,
  output logic [das_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output das_pkg::cfg_t               cfg_o
);

  das_pkg::cfg_t cfg_q;
  logic [2:0]    reg_idx;
  logic [2:0]    slot_sel;
  logic          is_event;

  assign reg_idx  = paddr[5:3];
  assign slot_sel = reg_idx - das_pkg::REG_EVENT0;
  assign is_event = (reg_idx >= das_pkg::REG_EVENT0) &&
                    ({1'b0, reg_idx} <= 4'(das_pkg::SLOTS));
  assign pready   = 1'b1;
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (reg_idx == das_pkg::REG_COUNT) begin
        cfg_q.count <= pwdata[2:0];
      end else if (is_event) begin
        cfg_q.events[slot_sel] <= pwdata[das_pkg::EVENT_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == das_pkg::REG_COUNT) begin
      prdata = das_pkg::DATA_W'(cfg_q.count);
    end else if (is_event) begin
      prdata = das_pkg::DATA_W'(cfg_q.events[slot_sel]);
    end
  end

endmodule

>>> hw/rtl/das_alu.sv
// Shared distance unit: seconds from now until an event minute, with day wrap,
// and a compare against the best distance so far. Depends on das_pkg.
module das_alu (
  input  logic [16:0]                now_i,
  input  logic [10:0]                minute_i,
  input  logic                       found_i,
  input  logic [das_pkg::DIST_W-1:0] best_i,
  output logic [das_pkg::DIST_W-1:0] dist_o,
  output logic                       less_o
);

  logic [das_pkg::DIST_W-1:0] ev_sec;
  logic [das_pkg::DIST_W-1:0] now_ext;

  assign ev_sec  = {1'b0, minute_i, 6'b0} - {5'b0, minute_i, 2'b0};
  assign now_ext = {1'b0, now_i};
  assign dist_o  = (ev_sec > now_ext) ? (ev_sec - now_ext)
                 : (ev_sec + das_pkg::DIST_W'(das_pkg::DAY_SECS) - now_ext);
  assign less_o  = !found_i || (dist_o < best_i);

endmodule

>>> hw/rtl/daily_alarm_scheduler_unit.sv
// Top level of the daily alarm scheduler: sequencer, alarm state and output register.
// Depends on das_pkg, das_regs, das_alu and assert_macros.svh.
//
// Input items arrive on in_valid_i/in_data_i and are taken when in_stall_o is low;
// results leave on out_valid_o/out_data_o and are taken when out_stall_i is low.
// A tick (mode 0) gives one fire item per event that fires, possibly none; the
// final one carries last. Modes 1, 2 and 3 give exactly one answer item.
// After an item is taken the block reduces the time to a minute, runs the tick
// filter, then walks the slots in use one slot per cycle; a query sends each slot
// through one shared distance unit. A query answer is then registered in the output
// register once that register is free, and the next item can be taken after it.
// A tick walks the slots again from slot zero up to the last one that fired and
// gives a fire item for each; a tick that the filter drops goes straight back to idle.
// A finished result waits in the output register while out_stall_i is high; the
// walk pauses on a fire item until the register frees, and a new item may be
// taken while the last result still waits. Reset clears the registers, marks
// every slot as never fired and forgets the last tick minute.
// Configuration is to be written through the APB-style port only while the block
// is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module daily_alarm_scheduler_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  das_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output das_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [das_pkg::ADDR_W-1:0]  paddr,
  input  logic [das_pkg::DATA_W-1:0]  pwdata,
  output logic [das_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT,
    ST_ANSWER
  } state_e;

  das_pkg::cfg_t cfg;

  das_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e                                state_q, state_d;
  das_pkg::in_item_t                     item_q, item_d;
  logic [10:0]                           minute_q, minute_d;
  logic [das_pkg::IDX_W-1:0]             idx_q, idx_d;
  logic                                  found_q, found_d;
  logic [das_pkg::DIST_W-1:0]            best_q, best_d;
  logic [das_pkg::IDX_W-1:0]             best_idx_q, best_idx_d;
  das_pkg::event_t                       best_ev_q, best_ev_d;
  logic [das_pkg::SLOTS-1:0]             mask_q, mask_d;
  logic [26:0]                           fired_q [das_pkg::SLOTS];
  logic [26:0]                           fired_d [das_pkg::SLOTS];
  logic [26:0]                           last_day_q, last_day_d;
  logic [10:0]                           last_min_q, last_min_d;
  logic                                  out_valid_q, out_valid_d;
  das_pkg::out_item_t                    out_q, out_d;

  das_pkg::event_t                       cur_ev;
  logic [das_pkg::IDX_W-1:0]             n_slots;
  logic                                  slot_active;
  logic                                  scan_end;
  logic                                  out_free;
  logic [34:0]                           prod;
  logic [das_pkg::DIST_W-1:0]            span;
  logic                                  less;
  logic                                  need_change;
  logic                                  found_eff;
  logic [31:0]                           cycle_time;
  logic [das_pkg::SLOTS-1:0]             mask_left;

  assign cur_ev      = cfg.events[idx_q];
  assign n_slots     = (cfg.count > das_pkg::IDX_W'(das_pkg::SLOTS))
                       ? das_pkg::IDX_W'(das_pkg::SLOTS) : cfg.count;
  assign slot_active = idx_q < n_slots;
  assign scan_end    = ({1'b0, idx_q} + 4'd1) >= {1'b0, n_slots};
  assign out_free    = !out_valid_q || !out_stall_i;
  assign prod        = 35'(item_q.sec_of_day) * 35'(das_pkg::MIN_RECIP);
  assign need_change = item_q.mode != das_pkg::MODE_NEXT;
  assign found_eff   = found_q && ((item_q.mode != das_pkg::MODE_SHOW) || item_q.clock_ok);
  assign cycle_time  = item_q.cycle_on ? item_q.cycle_left_sec : '0;
  assign mask_left   = mask_q & ~(das_pkg::SLOTS'(1) << idx_q);

  das_alu u_alu (
    .now_i    (item_q.sec_of_day),
    .minute_i (cur_ev.minute),
    .found_i  (found_q),
    .best_i   (best_q),
    .dist_o   (span),
    .less_o   (less)
  );

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    minute_d    = minute_q;
    idx_d       = idx_q;
    found_d     = found_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    best_ev_d   = best_ev_q;
    mask_d      = mask_q;
    fired_d     = fired_q;
    last_day_d  = last_day_q;
    last_min_d  = last_min_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          if (in_data_i.sec_of_day >= 17'(das_pkg::DAY_SECS)) begin
            item_d.sec_of_day = in_data_i.sec_of_day - 17'(das_pkg::DAY_SECS);
          end
          idx_d   = '0;
          found_d = 1'b0;
          mask_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        minute_d = prod[das_pkg::MIN_SHIFT +: 11];
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        if (item_q.mode == das_pkg::MODE_TICK) begin
          if (!item_q.clock_ok || (item_q.day_code == '0) ||
              ((item_q.day_code == last_day_q) && (minute_q == last_min_q))) begin
            state_d = ST_IDLE;
          end else begin
            last_day_d = item_q.day_code;
            last_min_d = minute_q;
            state_d    = ST_SCAN;
          end
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (item_q.mode == das_pkg::MODE_TICK) begin
          if (slot_active && cur_ev.enable && (cur_ev.minute == minute_q) &&
              (fired_q[idx_q] != item_q.day_code)) begin
            mask_d[idx_q]  = 1'b1;
            fired_d[idx_q] = item_q.day_code;
          end
        end else if (slot_active && cur_ev.enable && less &&
                     !(need_change && (cur_ev.action == item_q.current_app_mode))) begin
          found_d    = 1'b1;
          best_d     = span;
          best_idx_d = idx_q;
          best_ev_d  = cur_ev;
        end
        if (scan_end) begin
          idx_d = '0;
          if (item_q.mode != das_pkg::MODE_TICK) begin
            state_d = ST_ANSWER;
          end else if (mask_d != '0) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      ST_EMIT: begin
        if (!mask_q[idx_q]) begin
          idx_d = idx_q + 3'd1;
        end else if (out_free) begin
          out_valid_d          = 1'b1;
          out_d                = '0;
          out_d.kind           = das_pkg::KIND_FIRE;
          out_d.found          = 1'b1;
          out_d.slot_index     = idx_q;
          out_d.event_minute   = cur_ev.minute;
          out_d.event_action   = cur_ev.action;
          out_d.event_duration = cur_ev.duration;
          out_d.mode_differs   = cur_ev.action != item_q.current_app_mode;
          out_d.last           = mask_left == '0;
          mask_d               = mask_left;
          idx_d                = idx_q + 3'd1;
          if (mask_left == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ANSWER: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.kind  = (item_q.mode == das_pkg::MODE_SHOW) ? das_pkg::KIND_SHOW
                                                            : das_pkg::KIND_NEXT;
          out_d.last  = 1'b1;
          if (found_eff) begin
            out_d.found          = 1'b1;
            out_d.slot_index     = best_idx_q;
            out_d.event_minute   = best_ev_q.minute;
            out_d.event_action   = best_ev_q.action;
            out_d.event_duration = best_ev_q.duration;
            out_d.mode_differs   = best_ev_q.action != item_q.current_app_mode;
          end
          if (item_q.mode == das_pkg::MODE_SHOW) begin
            if (found_eff && ((cycle_time == '0) || (32'(best_q) < cycle_time))) begin
              out_d.wait_sec = 32'(best_q);
            end else begin
              out_d.wait_sec = cycle_time;
            end
          end else if (found_eff) begin
            out_d.wait_sec = 32'(best_q);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      minute_q    <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      best_idx_q  <= '0;
      best_ev_q   <= '0;
      mask_q      <= '0;
      fired_q     <= '{default: '0};
      last_day_q  <= das_pkg::DAY_NONE;
      last_min_q  <= das_pkg::MINUTE_NONE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      minute_q    <= minute_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      best_q      <= best_d;
      best_idx_q  <= best_idx_d;
      best_ev_q   <= best_ev_d;
      mask_q      <= mask_d;
      fired_q     <= fired_d;
      last_day_q  <= last_day_d;
      last_min_q  <= last_min_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  `ASSERT_IMPLIES(a_emit_has_fire, clk_i, rst_ni, state_q == ST_EMIT, mask_q != '0)
  `ASSERT_NEXT(a_one_item_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_IMPLIES(a_fire_item_shape, clk_i, rst_ni, out_valid_q && (out_q.kind == das_pkg::KIND_FIRE), out_q.found && (out_q.wait_sec == '0))

endmodule
